@@ sv/bftl_pkg.sv @@
// shared types and constants for the bitmap font text layout block
`timescale 1ns / 1ps
`default_nettype none

package bftl_pkg;

  localparam int unsigned GLYPH_W  = 8;
  localparam int unsigned CFG_IW   = 3;
  localparam int unsigned CFG_DW   = 12;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SRC_W    = 15;
  localparam int unsigned LINES_W  = 7;
  localparam int unsigned SPACING_W = 9;
  localparam int unsigned LENGTH_W = 12;

  localparam logic [GLYPH_W-1:0] SPACE_CODE = 8'h20;

  localparam logic [GLYPH_W-1:0]   RST_GLYPH_WIDTH   = 8'd8;
  localparam logic [GLYPH_W-1:0]   RST_GLYPH_HEIGHT  = 8'd8;
  localparam logic [GLYPH_W-1:0]   RST_GLYPH_COLUMNS = 8'd16;
  localparam logic [GLYPH_W-1:0]   RST_TABLE_LENGTH  = 8'd0;
  localparam logic [SPACING_W-1:0] RST_LINE_SPACING  = 9'h1FF;
  localparam logic [LENGTH_W-1:0]  RST_LINE_LENGTH   = 12'd0;

  typedef enum logic [CFG_IW-1:0] {
    REG_GLYPH_WIDTH   = 3'd0,
    REG_GLYPH_HEIGHT  = 3'd1,
    REG_GLYPH_COLUMNS = 3'd2,
    REG_TABLE_LENGTH  = 3'd3,
    REG_LINE_SPACING  = 3'd4,
    REG_LINE_LENGTH   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_TABLE = 1'b0,
    CMD_TEXT  = 1'b1
  } cmd_e;

endpackage

`default_nettype wire

@@ sv/bftl_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bftl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/bftl_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bftl_div import bftl_pkg::*; #(
  parameter int unsigned N = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [N-1:0]       dividend_i,
  input  wire logic [GLYPH_W-1:0] divisor_i,
  output logic                    done_o,
  output logic      [N-1:0]       quot_o,
  output logic      [GLYPH_W-1:0] rem_o
);

  localparam int unsigned CNTW = $clog2(N + 1);

  logic [N-1:0]       quo_q;
  logic [GLYPH_W-1:0] rem_q;
  logic [CNTW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [GLYPH_W:0]   shifted;
  logic [GLYPH_W:0]   diff;
  logic               ge;

  assign shifted = {rem_q, quo_q[N-1]};
  assign ge      = shifted >= {1'b0, divisor_i};
  assign diff    = shifted - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      cnt_q  <= CNTW'(N);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      quo_q <= N'({quo_q, ge});
      rem_q <= ge ? diff[GLYPH_W-1:0] : shifted[GLYPH_W-1:0];
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ sv/bitmap_font_text_layout_core.sv @@
// top level: character table, text buffer and layout sequencer
// a string is laid out after its last character arrives; a space with wrapping on
//   also looks ahead over the next word in the buffer to decide the wrap
// one string at a time: table writes and text appends are accepted only while idle
// the table search and the lookahead each step one ram entry at a time: read, then compare
// reset: config registers to their defaults, text buffer empty; rams hold junk
`timescale 1ns / 1ps
`default_nettype none

module bitmap_font_text_layout_core import bftl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 128,
  parameter int unsigned TEXT_DEPTH  = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CFG_IW-1:0]   cfg_index_i,
  input  wire logic [CFG_DW-1:0]   cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                command_i,
  input  wire logic [6:0]          table_index_i,
  input  wire logic [GLYPH_W-1:0]  char_code_i,
  input  wire logic signed [COORD_W-1:0] origin_x_i,
  input  wire logic signed [COORD_W-1:0] origin_y_i,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [SRC_W-1:0]         source_x_o,
  output logic [SRC_W-1:0]         source_y_o,
  output logic signed [COORD_W-1:0] place_x_o,
  output logic signed [COORD_W-1:0] place_y_o,
  output logic                     drawn_o,
  output logic [LINES_W-1:0]       line_count_o,
  output logic                     final_res_o
);

  localparam int unsigned TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TJW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(TEXT_DEPTH + 1);
  localparam logic [TJW-1:0] TBL_MAX = TJW'(TABLE_DEPTH);
  localparam logic [CW-1:0]  TXT_MAX = CW'(TEXT_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_CHAR, S_TRD, S_TCMP, S_DIV, S_DWAIT,
    S_MUL, S_LRD, S_LCMP, S_WRAP, S_OUT
  } state_e;

  // configuration registers
  logic [GLYPH_W-1:0]   gw_q, gh_q, gc_q, tl_q;
  logic [SPACING_W-1:0] ls_q;
  logic [LENGTH_W-1:0]  ll_q;

  state_e               state_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        i_q;
  logic [CW-1:0]        lj_q;
  logic [TJW-1:0]       tj_q;
  logic [TAW-1:0]       idx_q;
  logic [GLYPH_W-1:0]   c_q;
  logic [COORD_W-1:0]   start_x_q, start_y_q;
  logic [COORD_W-1:0]   py_q;
  logic [COORD_W-1:0]   off_q;
  logic [COORD_W-1:0]   chk_q;
  logic [LINES_W-1:0]   lines_q;
  logic                 drawn_q;
  logic [SRC_W-1:0]     sx_q, sy_q;

  logic                 in_fire, tbl_we, buf_we, tbl_re, buf_re;
  logic [GLYPH_W-1:0]   tbl_rdata, buf_rdata;
  logic [BAW-1:0]       buf_raddr;
  logic [TJW-1:0]       tbl_limit;
  logic [GLYPH_W-1:0]   cols;
  logic                 wrap_en;
  logic                 div_done;
  logic [TAW-1:0]       div_quot;
  logic [GLYPH_W-1:0]   div_rem;
  logic [2*GLYPH_W-1:0] prod_x, prod_y;

  assign in_fire   = in_valid_i && in_ready_o;
  assign tbl_we    = in_fire && (command_i == CMD_TABLE)
                     && ({2'b00, table_index_i} < 9'(TABLE_DEPTH));
  assign buf_we    = in_fire && (command_i == CMD_TEXT) && (count_q < TXT_MAX);
  assign tbl_re    = (state_q == S_TRD);
  assign buf_re    = (state_q == S_FETCH) || ((state_q == S_LRD) && (lj_q != count_q));
  assign buf_raddr = (state_q == S_FETCH) ? i_q[BAW-1:0] : lj_q[BAW-1:0];

  assign tbl_limit = ({1'b0, tl_q} >= 9'(TABLE_DEPTH)) ? TBL_MAX : TJW'(tl_q);
  assign cols      = (gc_q == '0) ? GLYPH_W'(1) : gc_q;
  assign wrap_en   = !ls_q[SPACING_W-1] && (ll_q != '0);

  assign prod_x = (2*GLYPH_W)'(gw_q) * (2*GLYPH_W)'(div_rem);
  assign prod_y = (2*GLYPH_W)'(gh_q) * (2*GLYPH_W)'(div_quot);

  bftl_ram #(.WIDTH(GLYPH_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (TAW'(table_index_i)),
    .wdata_i (char_code_i),
    .re_i    (tbl_re),
    .raddr_i (tj_q[TAW-1:0]),
    .rdata_o (tbl_rdata)
  );

  bftl_ram #(.WIDTH(GLYPH_W), .DEPTH(TEXT_DEPTH)) u_text (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (count_q[BAW-1:0]),
    .wdata_i (char_code_i),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  bftl_div #(.N(TAW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIV),
    .dividend_i (idx_q),
    .divisor_i  (cols),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= RST_GLYPH_WIDTH;
      gh_q <= RST_GLYPH_HEIGHT;
      gc_q <= RST_GLYPH_COLUMNS;
      tl_q <= RST_TABLE_LENGTH;
      ls_q <= RST_LINE_SPACING;
      ll_q <= RST_LINE_LENGTH;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GLYPH_WIDTH:   gw_q <= cfg_data_i[GLYPH_W-1:0];
        REG_GLYPH_HEIGHT:  gh_q <= cfg_data_i[GLYPH_W-1:0];
        REG_GLYPH_COLUMNS: gc_q <= cfg_data_i[GLYPH_W-1:0];
        REG_TABLE_LENGTH:  tl_q <= cfg_data_i[GLYPH_W-1:0];
        REG_LINE_SPACING:  ls_q <= cfg_data_i[SPACING_W-1:0];
        REG_LINE_LENGTH:   ll_q <= cfg_data_i[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // layout sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      i_q       <= '0;
      lj_q      <= '0;
      tj_q      <= '0;
      idx_q     <= '0;
      c_q       <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      py_q      <= '0;
      off_q     <= '0;
      chk_q     <= '0;
      lines_q   <= LINES_W'(1);
      drawn_q   <= 1'b1;
      sx_q      <= '0;
      sy_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && (command_i == CMD_TEXT)) begin
            if (count_q == '0) begin
              start_x_q <= origin_x_i;
              start_y_q <= origin_y_i;
            end
            if (count_q < TXT_MAX) begin
              count_q <= count_q + 1'b1;
            end
            if (last_i) begin
              i_q     <= '0;
              off_q   <= '0;
              lines_q <= LINES_W'(1);
              py_q    <= (count_q == '0) ? origin_y_i : start_y_q;
              state_q <= S_FETCH;
            end
          end
        end
        S_FETCH: state_q <= S_CHAR;
        S_CHAR: begin
          c_q  <= buf_rdata;
          tj_q <= '0;
          if (tbl_limit == '0) begin
            idx_q   <= '0;
            state_q <= S_DIV;
          end else begin
            state_q <= S_TRD;
          end
        end
        S_TRD: state_q <= S_TCMP;
        S_TCMP: begin
          // first matching entry wins, no match gives glyph 0
          if (tbl_rdata == c_q) begin
            idx_q   <= tj_q[TAW-1:0];
            state_q <= S_DIV;
          end else if (tj_q + 1'b1 == tbl_limit) begin
            idx_q   <= '0;
            state_q <= S_DIV;
          end else begin
            tj_q    <= tj_q + 1'b1;
            state_q <= S_TRD;
          end
        end
        S_DIV: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          sx_q <= prod_x[SRC_W-1:0];
          sy_q <= prod_y[SRC_W-1:0];
          if ((c_q == SPACE_CODE) && wrap_en) begin
            chk_q   <= off_q;
            lj_q    <= i_q + 1'b1;
            state_q <= S_LRD;
          end else begin
            drawn_q <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_LRD: begin
          state_q <= (lj_q == count_q) ? S_WRAP : S_LCMP;
        end
        S_LCMP: begin
          // width of the word after the space
          if (buf_rdata == SPACE_CODE) begin
            state_q <= S_WRAP;
          end else begin
            chk_q   <= chk_q + COORD_W'(gw_q);
            lj_q    <= lj_q + 1'b1;
            state_q <= S_LRD;
          end
        end
        S_WRAP: begin
          if (chk_q > COORD_W'(ll_q)) begin
            off_q   <= '0;
            py_q    <= py_q + COORD_W'(gh_q) + COORD_W'(ls_q[SPACING_W-2:0]);
            lines_q <= lines_q + 1'b1;
            drawn_q <= 1'b0;
          end else begin
            drawn_q <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            if (drawn_q) begin
              off_q <= off_q + COORD_W'(gw_q);
            end
            i_q <= i_q + 1'b1;
            if (final_res_o) begin
              count_q <= '0;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_FETCH;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign source_x_o   = sx_q;
  assign source_y_o   = sy_q;
  assign place_x_o    = start_x_q + off_q;
  assign place_y_o    = py_q;
  assign drawn_o      = drawn_q;
  assign line_count_o = lines_q;
  assign final_res_o  = (i_q + 1'b1 == count_q);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a result is pending");

  a_lines_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_count_o != '0))
    else $error("line count is zero");

  a_wrap_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !drawn_o) |-> (place_x_o == start_x_q))
    else $error("swallowed space not at line start");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TXT_MAX)
    else $error("text count beyond buffer");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && final_res_o) |=> (in_ready_o && count_q == '0))
    else $error("buffer not cleared after final result");

endmodule

`default_nettype wire

@@ tb/sv/bitmap_font_text_layout_core_tb.sv @@
// testbench for the bitmap font text layout core: directed and random strings, scoreboard check
`timescale 1ns / 1ps

module bitmap_font_text_layout_core_tb;
  import bftl_pkg::*;

  localparam int unsigned TAB_DEPTH     = 128;
  localparam int unsigned BUF_DEPTH     = 64;
  localparam int unsigned SETTLE_CYCLES = 500;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned ITEM_TARGET   = 420;
  localparam int unsigned PHASE_ITEMS   = 35;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd6;

  typedef struct packed {
    cmd_e                      command;
    logic [6:0]                table_index;
    logic [GLYPH_W-1:0]        char_code;
    logic [COORD_W-1:0]        origin_x;
    logic [COORD_W-1:0]        origin_y;
    logic                      last;
  } text_item_t;

  typedef struct packed {
    logic [SRC_W-1:0]   source_x;
    logic [SRC_W-1:0]   source_y;
    logic [COORD_W-1:0] place_x;
    logic [COORD_W-1:0] place_y;
    logic               drawn;
    logic [LINES_W-1:0] line_count;
    logic               final_res;
  } glyph_place_t;

  class layout_scoreboard;
    logic [GLYPH_W-1:0] glyph_tab [TAB_DEPTH];
    bit                 tab_written [TAB_DEPTH];
    logic [GLYPH_W-1:0] text_buf [BUF_DEPTH];
    int unsigned        text_cnt;
    int                 start_x, start_y;
    int unsigned        cell_w, cell_h, sheet_cols, tab_len, wrap_len;
    int                 spacing;
    glyph_place_t       placements [$];
    int                 errors;

    function new();
      text_cnt   = 0;
      start_x    = 0;
      start_y    = 0;
      cell_w     = RST_GLYPH_WIDTH;
      cell_h     = RST_GLYPH_HEIGHT;
      sheet_cols = RST_GLYPH_COLUMNS;
      tab_len    = RST_TABLE_LENGTH;
      spacing    = $signed(RST_LINE_SPACING);
      wrap_len   = RST_LINE_LENGTH;
      errors     = 0;
      foreach (tab_written[j]) tab_written[j] = 1'b0;
    endfunction

    function void apply_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      logic signed [SPACING_W-1:0] sp;
      sp = data[SPACING_W-1:0];
      case (idx)
        REG_GLYPH_WIDTH:   cell_w = data[7:0];
        REG_GLYPH_HEIGHT:  cell_h = data[7:0];
        REG_GLYPH_COLUMNS: sheet_cols = data[7:0];
        REG_TABLE_LENGTH:  tab_len = data[7:0];
        REG_LINE_SPACING:  spacing = sp;
        REG_LINE_LENGTH:   wrap_len = data[LENGTH_W-1:0];
        default: ;
      endcase
    endfunction

    // first matching entry, 0 when nothing matches
    function int unsigned glyph_index(logic [GLYPH_W-1:0] code);
      int unsigned n;
      n = (tab_len < TAB_DEPTH) ? tab_len : TAB_DEPTH;
      for (int unsigned j = 0; j < n; j++)
        if (glyph_tab[j] == code) return j;
      return 0;
    endfunction

    function void lay_out_string();
      int unsigned  cols, idx, n, j;
      int           px, py, reach, lines;
      bit           wrap_on, drawn;
      glyph_place_t p;
      cols    = (sheet_cols == 0) ? 1 : sheet_cols;
      wrap_on = (spacing >= 0) && (wrap_len > 0);
      px      = start_x;
      py      = start_y;
      lines   = 1;
      n       = text_cnt;
      for (int unsigned i = 0; i < n; i++) begin
        idx        = glyph_index(text_buf[i]);
        p.source_x = SRC_W'(cell_w * (idx % cols));
        p.source_y = SRC_W'(cell_h * (idx / cols));
        drawn      = 1'b1;
        if (text_buf[i] == SPACE_CODE && wrap_on) begin
          // look ahead over the next word held in the buffer
          reach = px;
          for (j = i + 1; j < n && text_buf[j] != SPACE_CODE; j++) reach += cell_w;
          if (reach - start_x > int'(wrap_len)) begin
            px    = start_x;
            py    = py + int'(cell_h) + spacing;
            lines = lines + 1;
            drawn = 1'b0;
          end
        end
        p.place_x    = px[COORD_W-1:0];
        p.place_y    = py[COORD_W-1:0];
        p.drawn      = drawn;
        p.line_count = lines[LINES_W-1:0];
        p.final_res  = (i + 1 == n);
        placements.push_back(p);
        if (drawn) px += cell_w;
      end
      text_cnt = 0;
    endfunction

    function void note_item(text_item_t it);
      if (it.command == CMD_TABLE) begin
        glyph_tab[it.table_index]   = it.char_code;
        tab_written[it.table_index] = 1'b1;
        return;
      end
      if (text_cnt == 0) begin
        start_x = {{16{it.origin_x[COORD_W-1]}}, it.origin_x};
        start_y = {{16{it.origin_y[COORD_W-1]}}, it.origin_y};
      end
      // characters past the buffer are dropped
      if (text_cnt < BUF_DEPTH) begin
        text_buf[text_cnt] = it.char_code;
        text_cnt++;
      end
      if (it.last) lay_out_string();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(glyph_place_t got);
      glyph_place_t want;
      if (placements.size() == 0) begin
        $display("%0t: result with nothing expected, place %0d,%0d", $time,
                 got.place_x, got.place_y);
        errors++;
        return;
      end
      want = placements.pop_front();
      compare_field("source_x", want.source_x, got.source_x);
      compare_field("source_y", want.source_y, got.source_y);
      compare_field("place_x", want.place_x, got.place_x);
      compare_field("place_y", want.place_y, got.place_y);
      compare_field("drawn", want.drawn, got.drawn);
      compare_field("line_count", want.line_count, got.line_count);
      compare_field("final_res", want.final_res, got.final_res);
    endfunction

    function int unsigned pending();
      return placements.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_IW-1:0]            cfg_index_i;
  logic [CFG_DW-1:0]            cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         command_i;
  logic [6:0]                   table_index_i;
  logic [GLYPH_W-1:0]           char_code_i;
  logic signed [COORD_W-1:0]    origin_x_i;
  logic signed [COORD_W-1:0]    origin_y_i;
  logic                         last_i;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [SRC_W-1:0]             source_x_o;
  logic [SRC_W-1:0]             source_y_o;
  logic signed [COORD_W-1:0]    place_x_o;
  logic signed [COORD_W-1:0]    place_y_o;
  logic                         drawn_o;
  logic [LINES_W-1:0]           line_count_o;
  logic                         final_res_o;

  layout_scoreboard sb;
  glyph_place_t     seen_place;
  bit               calm;
  int unsigned      hold_req, hold_seen, hold_left;
  int unsigned      items_sent;
  int unsigned      idle_cycles;

  bitmap_font_text_layout_core u_top (.*);

  assign seen_place = {source_x_o, source_y_o, place_x_o, place_y_o,
                       drawn_o, line_count_o, final_res_o};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(seen_place);
  end

  // any transaction restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("bitmap_font_text_layout_core_tb failed");
        $finish;
      end
    end
  end

  // receiver side, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 21);
    end
  end

  task automatic send_item(text_item_t it);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= it.command;
    table_index_i <= it.table_index;
    char_code_i   <= it.char_code;
    origin_x_i    <= it.origin_x;
    origin_y_i    <= it.origin_y;
    last_i        <= it.last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_entry(int unsigned idx, logic [GLYPH_W-1:0] code, logic last);
    text_item_t it;
    it.command     = CMD_TABLE;
    it.table_index = idx[6:0];
    it.char_code   = code;
    it.origin_x    = 16'($urandom);
    it.origin_y    = 16'($urandom);
    it.last        = last;
    send_item(it);
  endtask

  task automatic put_char(logic [GLYPH_W-1:0] code, logic last,
                          logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
    text_item_t it;
    it.command     = CMD_TEXT;
    it.table_index = 7'($urandom);
    it.char_code   = code;
    it.origin_x    = ox;
    it.origin_y    = oy;
    it.last        = last;
    send_item(it);
  endtask

  function automatic logic [GLYPH_W-1:0] pick_code();
    int unsigned r, n;
    n = (sb.tab_len < TAB_DEPTH) ? sb.tab_len : TAB_DEPTH;
    r = $urandom_range(99);
    if (r < 30) return SPACE_CODE;
    if (r < 70 && n > 0) return sb.glyph_tab[$urandom_range(n - 1)];
    if (r < 80) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_string(int unsigned len, bit squeeze);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0)
        put_entry($urandom_range(TAB_DEPTH - 1), 8'($urandom), 1'($urandom));
      if (squeeze && i == len - 1) hold_req++;
      put_char(pick_code(), i == len - 1, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic program_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  // upper data bits beyond a register's width are junk on purpose
  task automatic configure(input logic [7:0] gw, input logic [7:0] gh,
                           input logic [7:0] cols, input logic [7:0] tlen,
                           input logic [8:0] sp, input logic [11:0] len);
    program_reg(REG_GLYPH_WIDTH, {4'($urandom), gw});
    program_reg(REG_GLYPH_HEIGHT, {4'($urandom), gh});
    program_reg(REG_GLYPH_COLUMNS, {4'($urandom), cols});
    program_reg(REG_TABLE_LENGTH, {4'($urandom), tlen});
    program_reg(REG_LINE_SPACING, {3'($urandom), sp});
    program_reg(REG_LINE_LENGTH, len);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for the block to drain, then let the tail of its work pass
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // every entry the search can reach must have been written
  task automatic fill_table();
    int unsigned n;
    n = (sb.tab_len < TAB_DEPTH) ? sb.tab_len : TAB_DEPTH;
    for (int unsigned j = 0; j < n; j++)
      if (!sb.tab_written[j]) put_entry(j, 8'($urandom), 1'($urandom));
  endtask

  task automatic random_phase(int unsigned phase);
    logic [7:0]  gw, gh, cols, tlen;
    logic [8:0]  sp;
    logic [11:0] len;
    int unsigned start, slen;
    bit          first;
    case ($urandom_range(9))
      0: gw = 8'd255;
      1: gw = 8'd1;
      2: gw = 8'd0;
      default: gw = 8'($urandom_range(16, 2));
    endcase
    case ($urandom_range(9))
      0: gh = 8'd255;
      1: gh = 8'd1;
      2: gh = 8'd0;
      default: gh = 8'($urandom_range(16, 2));
    endcase
    case ($urandom_range(9))
      0: cols = 8'd0;
      1: cols = 8'd1;
      2: cols = 8'd128;
      3: cols = 8'd255;
      default: cols = 8'($urandom_range(20, 1));
    endcase
    case ($urandom_range(7))
      0: tlen = 8'd0;
      1: tlen = 8'd128;
      2: tlen = 8'($urandom_range(254, 129));
      3: tlen = 8'd255;
      4, 5: tlen = 8'($urandom_range(16, 1));
      default: tlen = 8'($urandom_range(128, 1));
    endcase
    case ($urandom_range(9))
      0: sp = 9'h1FF;
      1: sp = {1'b1, 8'($urandom)};
      2: sp = 9'd255;
      3: sp = 9'd0;
      default: sp = 9'($urandom_range(20));
    endcase
    case ($urandom_range(9))
      0: len = 12'd0;
      1: len = 12'd4095;
      2: len = 12'($urandom);
      default: len = 12'($urandom_range(150, 1));
    endcase
    if (phase == 1) tlen = 8'd255;
    if (phase == 4) tlen = 8'd128;
    calm = (phase == 3 || phase == 5);
    configure(gw, gh, cols, tlen, sp, len);
    fill_table();
    start = items_sent;
    first = 1'b1;
    while (items_sent - start < PHASE_ITEMS) begin
      // the first string of every fourth phase, from phase 2, can fill or overrun the text buffer
      if (first && phase % 4 == 2) slen = $urandom_range(70, 64);
      else slen = $urandom_range(12, 1);
      send_string(slen, first && phase == 5);
      first = 1'b0;
    end
  endtask

  initial begin
    int unsigned phase;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = CMD_TABLE;
    table_index_i = '0;
    char_code_i   = '0;
    origin_x_i    = '0;
    origin_y_i    = '0;
    last_i        = 1'b0;
    calm          = 1'b0;
    hold_req      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    items_sent    = 0;
    idle_cycles   = 0;
    sb            = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table: everything maps to glyph 0; code zero and a table write marked last
    put_char(8'h00, 1'b0, 16'h8000, 16'h7FFF);
    put_entry(0, 8'h41, 1'b1);
    put_char(8'hFF, 1'b0, 16'h0000, 16'h0000);
    put_char(SPACE_CODE, 1'b1, 16'hFFFF, 16'hFFFF);
    put_entry(1, SPACE_CODE, 1'b1);
    put_entry(2, 8'h42, 1'b0);
    put_entry(3, 8'h00, 1'b1);
    put_entry(4, 8'h7F, 1'b0);
    put_entry(5, 8'hFF, 1'b0);
    put_entry(127, 8'hFF, 1'b1);
    settle();

    // widest cells, zero columns, tight wrap near the top of the x range
    program_reg(REG_UNUSED, 12'($urandom));
    configure(8'd255, 8'd255, 8'd0, 8'd6, 9'd0, 12'd300);
    put_char(8'h41, 1'b0, 16'h7FFF, 16'h8000);
    put_char(SPACE_CODE, 1'b0, 16'h0000, 16'h0000);
    put_char(8'h42, 1'b0, 16'h0000, 16'h0000);
    put_char(8'h42, 1'b0, 16'h0000, 16'h0000);
    put_char(SPACE_CODE, 1'b0, 16'h0000, 16'h0000);
    put_char(8'h41, 1'b1, 16'h0000, 16'h0000);
    settle();

    // widest line, largest spacing, space first and last
    configure(8'd8, 8'd1, 8'd128, 8'd6, 9'd255, 12'd4095);
    put_char(SPACE_CODE, 1'b0, 16'h1234, 16'hFEDC);
    put_char(8'h42, 1'b0, 16'h0000, 16'h0000);
    put_char(SPACE_CODE, 1'b1, 16'h0000, 16'h0000);
    settle();

    // consecutive spaces each start a line
    configure(8'd8, 8'd8, 8'd16, 8'd6, 9'd0, 12'd1);
    put_char(8'h41, 1'b0, 16'h0010, 16'h0020);
    put_char(SPACE_CODE, 1'b0, 16'h0000, 16'h0000);
    put_char(SPACE_CODE, 1'b0, 16'h0000, 16'h0000);
    put_char(8'h41, 1'b1, 16'h0000, 16'h0000);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      random_phase(phase);
      phase++;
    end
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bitmap_font_text_layout_core_tb passed");
    end else begin
      $display("bitmap_font_text_layout_core_tb failed");
    end
    $finish;
  end

endmodule
